@@ hw/rtl/generational_handle_allocator_core_macros.svh @@
// Assertion macros for the generational handle allocator.
// Used by the top level; relies on i_clk and i_rst_n being in scope.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_CORE_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_CORE_MACROS_SVH

// Combinational invariant, checked every clock outside reset.
`define GHA_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Trigger in one cycle implies consequence in the next.
`define GHA_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/gha_pkg.sv @@
// Package for the generational handle allocator: request/response types,
// controller state, command and status structs. No dependencies.
package gha_pkg;

    localparam int IDX_IN_W  = 16;
    localparam int GEN_IN_W  = 16;
    localparam int RCNT_W    = 5;
    localparam int IDX_OUT_W = 10;
    localparam int GEN_OUT_W = 16;

    typedef enum logic [2:0] {
        FUNC_CREATE   = 3'd0,
        FUNC_RESERVE  = 3'd1,
        FUNC_COMMIT   = 3'd2,
        FUNC_RANGE    = 3'd3,
        FUNC_DESTROY  = 3'd4,
        FUNC_IS_ALIVE = 3'd5,
        FUNC_GET      = 3'd6,
        FUNC_CLEAR    = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_FINE   = 2'd0,
        ST_BUDGET = 2'd1,
        ST_STALE  = 2'd2
    } t_status;

    typedef struct packed {
        t_func                 func;
        logic                  handle_valid;
        logic [IDX_IN_W-1:0]   slot_index;
        logic [GEN_IN_W-1:0]   slot_generation;
        logic [RCNT_W-1:0]     range_count;
    } t_req;

    typedef struct packed {
        logic                  ok;
        t_status               status;
        logic                  out_valid;
        logic [IDX_OUT_W-1:0]  out_index;
        logic [GEN_OUT_W-1:0]  out_generation;
        logic                  last;
    } t_rsp;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_POP,
        S_EXEC,
        S_RRD,
        S_RWR,
        S_CRD,
        S_CWR,
        S_CDONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic pop;
        logic exec;
        logic rng_rd;
        logic rng_wr;
        logic clr_rd;
        logic clr_wr;
        logic clr_done;
        logic init_wr;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic pop_needed;
        logic out_free;
        logic range_go;
        logic clear_go;
        logic range_last;
        logic sweep_last;
    } t_sts;

endpackage

@@ hw/rtl/gha_ctrl.sv @@
// Controller state machine of the handle allocator.
// Depends on gha_pkg; drives t_cmd to gha_dpath, reads t_sts back.
module gha_ctrl
    import gha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:  if (i_sts.init_last) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = i_sts.pop_needed ? S_POP : S_EXEC;
            S_POP:   n_state = S_EXEC;
            S_EXEC: begin
                if (i_sts.out_free) begin
                    priority if (i_sts.range_go) n_state = S_RRD;
                    else if (i_sts.clear_go)     n_state = S_CRD;
                    else                         n_state = S_IDLE;
                end
            end
            S_RRD:   n_state = S_RWR;
            S_RWR:   if (i_sts.out_free) n_state = i_sts.range_last ? S_IDLE : S_RRD;
            S_CRD:   n_state = S_CWR;
            S_CWR:   n_state = i_sts.sweep_last ? S_CDONE : S_CRD;
            S_CDONE: if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_in_ready     = (r_state == S_IDLE);
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.pop      = (r_state == S_POP);
        o_cmd.exec     = (r_state == S_EXEC) && i_sts.out_free;
        o_cmd.rng_rd   = (r_state == S_RRD);
        o_cmd.rng_wr   = (r_state == S_RWR) && i_sts.out_free;
        o_cmd.clr_rd   = (r_state == S_CRD);
        o_cmd.clr_wr   = (r_state == S_CWR);
        o_cmd.clr_done = (r_state == S_CDONE) && i_sts.out_free;
        o_cmd.init_wr  = (r_state == S_INIT);
    end

endmodule

@@ hw/rtl/gha_dpath.sv @@
// Datapath of the handle allocator: slot table, free stack, counters and
// the result register. Depends on gha_pkg; steered by gha_ctrl commands.
module gha_dpath
    import gha_pkg::*;
#(
    parameter int MAX_ENTITIES = 1024,
    parameter int GEN_BITS     = 16,
    parameter int MAX_RANGE    = 16
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_req i_in_req,
    output t_sts o_sts,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_rsp
);

    localparam int IDX_W = $clog2(MAX_ENTITIES);
    localparam int CNT_W = $clog2(MAX_ENTITIES + 1);

    // slot table entry: alive bit on top of the generation
    logic [GEN_BITS:0]  r_tab_mem [MAX_ENTITIES];
    logic [GEN_BITS:0]  r_tab_rd;
    logic [IDX_W-1:0]   r_fs_mem  [MAX_ENTITIES];
    logic [IDX_W-1:0]   r_fs_rd;

    logic [CNT_W-1:0]   r_depth, n_depth;
    logic [CNT_W-1:0]   r_fresh, n_fresh;
    logic [IDX_W-1:0]   r_ptr;
    logic [RCNT_W-1:0]  r_left;
    logic [IDX_W-1:0]   r_n;
    t_req               r_req;
    logic               r_out_valid;
    t_rsp               r_rsp, rsp;
    logic               emit;

    logic               tab_we, tab_re;
    logic [IDX_W-1:0]   tab_wa, tab_ra;
    logic [GEN_BITS:0]  tab_wd;
    logic               fs_we;
    logic [CNT_W-1:0]   depth_m1;

    logic [IDX_IN_W+IDX_W-1:0]   in_idx_ext, req_idx_ext;
    logic [IDX_W-1:0]            in_idx, req_idx, fresh_idx;
    logic [GEN_IN_W+GEN_BITS-1:0] req_gen_ext;
    logic [GEN_BITS-1:0]         req_gen, tab_gen;
    logic                        tab_alive, in_range, hok;
    logic                        fresh_ok, range_fit, out_free;

    function automatic t_rsp mk_rsp(input logic ok, input t_status st, input logic vld,
                                    input logic [IDX_W-1:0] idx,
                                    input logic [GEN_BITS-1:0] gen, input logic lst);
        logic [IDX_W+IDX_OUT_W-1:0]    ie;
        logic [GEN_BITS+GEN_OUT_W-1:0] ge;
        t_rsp                          r;
        ie = {{IDX_OUT_W{1'b0}}, idx};
        ge = {{GEN_OUT_W{1'b0}}, gen};
        r.ok             = ok;
        r.status         = st;
        r.out_valid      = vld;
        r.out_index      = vld ? ie[IDX_OUT_W-1:0] : '0;
        r.out_generation = vld ? ge[GEN_OUT_W-1:0] : '0;
        r.last           = lst;
        return r;
    endfunction

    assign in_idx_ext  = {{IDX_W{1'b0}}, i_in_req.slot_index};
    assign in_idx      = in_idx_ext[IDX_W-1:0];
    assign req_idx_ext = {{IDX_W{1'b0}}, r_req.slot_index};
    assign req_idx     = req_idx_ext[IDX_W-1:0];
    assign req_gen_ext = {{GEN_BITS{1'b0}}, r_req.slot_generation};
    assign req_gen     = req_gen_ext[GEN_BITS-1:0];
    assign fresh_idx   = r_fresh[IDX_W-1:0];
    assign depth_m1    = r_depth - CNT_W'(1);
    assign tab_alive   = r_tab_rd[GEN_BITS];
    assign tab_gen     = r_tab_rd[GEN_BITS-1:0];
    assign in_range    = {1'b0, r_req.slot_index} < (IDX_IN_W+1)'(MAX_ENTITIES);
    assign hok         = r_req.handle_valid && in_range && tab_alive && (tab_gen == req_gen);
    assign fresh_ok    = r_fresh < CNT_W'(MAX_ENTITIES);
    assign range_fit   = (32'(r_req.range_count) <= 32'(MAX_RANGE)) &&
                         ((CNT_W+1)'(r_fresh) + (CNT_W+1)'(r_req.range_count)
                          <= (CNT_W+1)'(MAX_ENTITIES));
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts            = '0;
        o_sts.init_last  = (r_ptr == IDX_W'(MAX_ENTITIES - 1));
        o_sts.pop_needed = (i_in_req.func == FUNC_CREATE) && (r_depth != '0);
        o_sts.out_free   = out_free;
        o_sts.range_go   = (r_req.func == FUNC_RANGE) && (r_req.range_count != '0) &&
                           range_fit;
        o_sts.clear_go   = (r_req.func == FUNC_CLEAR) && (r_fresh != '0);
        o_sts.range_last = (r_left == RCNT_W'(1));
        o_sts.sweep_last = (CNT_W'(r_ptr) + CNT_W'(1) == r_fresh);
    end

    // table read address; the read data holds while a write waits on the output
    assign tab_re = i_cmd.accept || i_cmd.pop || i_cmd.rng_rd || i_cmd.clr_rd;

    always_comb begin
        priority if (i_cmd.accept)
            tab_ra = (i_in_req.func == FUNC_CREATE || i_in_req.func == FUNC_RESERVE) ?
                     fresh_idx : in_idx;
        else if (i_cmd.pop)    tab_ra = r_fs_rd;
        else if (i_cmd.rng_rd) tab_ra = fresh_idx;
        else                   tab_ra = r_ptr;
    end

    // operation datapath
    always_comb begin
        tab_we  = 1'b0;
        tab_wa  = r_ptr;
        tab_wd  = '0;
        fs_we   = 1'b0;
        n_depth = r_depth;
        n_fresh = r_fresh;
        emit    = 1'b0;
        rsp     = mk_rsp(1'b1, ST_FINE, 1'b0, '0, '0, 1'b1);
        priority if (i_cmd.init_wr) begin
            tab_we = 1'b1;
        end else if (i_cmd.clr_wr) begin
            tab_we = 1'b1;
            tab_wd = {1'b0, tab_gen + GEN_BITS'(tab_alive)};
        end else if (i_cmd.clr_done) begin
            emit    = 1'b1;
            n_depth = '0;
            n_fresh = '0;
        end else if (i_cmd.rng_wr) begin
            tab_we  = 1'b1;
            tab_wa  = fresh_idx;
            tab_wd  = {1'b1, tab_gen};
            n_fresh = r_fresh + CNT_W'(1);
            emit    = 1'b1;
            rsp     = mk_rsp(1'b1, ST_FINE, 1'b1, fresh_idx, tab_gen, o_sts.range_last);
        end else if (i_cmd.exec) begin
            emit   = 1'b1;
            tab_wa = r_n;
            unique case (r_req.func)
                FUNC_CREATE: begin
                    if (r_depth != '0 || fresh_ok) begin
                        if (r_depth != '0) n_depth = depth_m1;
                        else               n_fresh = r_fresh + CNT_W'(1);
                        tab_we = 1'b1;
                        tab_wd = {1'b1, tab_gen};
                        rsp    = mk_rsp(1'b1, ST_FINE, 1'b1, r_n, tab_gen, 1'b1);
                    end else begin
                        rsp = mk_rsp(1'b0, ST_BUDGET, 1'b0, '0, '0, 1'b1);
                    end
                end
                FUNC_RESERVE: begin
                    if (fresh_ok) begin
                        n_fresh = r_fresh + CNT_W'(1);
                        rsp     = mk_rsp(1'b1, ST_FINE, 1'b1, r_n, tab_gen, 1'b1);
                    end else begin
                        rsp = mk_rsp(1'b0, ST_BUDGET, 1'b0, '0, '0, 1'b1);
                    end
                end
                FUNC_COMMIT: begin
                    if (r_req.handle_valid && in_range) begin
                        tab_we = 1'b1;
                        tab_wd = {1'b1, tab_gen};
                    end else begin
                        rsp = mk_rsp(1'b0, ST_STALE, 1'b0, '0, '0, 1'b1);
                    end
                end
                FUNC_RANGE: begin
                    if (r_req.range_count == '0) begin
                        emit = 1'b1;
                    end else if (range_fit) begin
                        emit = 1'b0;
                    end else begin
                        rsp = mk_rsp(1'b0, ST_BUDGET, 1'b0, '0, '0, 1'b1);
                    end
                end
                FUNC_DESTROY: begin
                    if (hok) begin
                        tab_we = 1'b1;
                        tab_wd = {1'b0, tab_gen + GEN_BITS'(1)};
                        if (r_depth < CNT_W'(MAX_ENTITIES)) begin
                            fs_we   = 1'b1;
                            n_depth = r_depth + CNT_W'(1);
                        end
                    end else begin
                        rsp = mk_rsp(1'b0, ST_STALE, 1'b0, '0, '0, 1'b1);
                    end
                end
                FUNC_IS_ALIVE: begin
                    if (!hok) rsp = mk_rsp(1'b0, ST_STALE, 1'b0, '0, '0, 1'b1);
                end
                FUNC_GET: begin
                    if (in_range && tab_alive)
                        rsp = mk_rsp(1'b1, ST_FINE, 1'b1, req_idx, tab_gen, 1'b1);
                    else
                        rsp = mk_rsp(1'b0, ST_STALE, 1'b0, '0, '0, 1'b1);
                end
                FUNC_CLEAR: begin
                    if (r_fresh == '0) begin
                        n_depth = '0;
                    end else begin
                        emit = 1'b0;
                    end
                end
                default: emit = 1'b0;
            endcase
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (tab_we) r_tab_mem[tab_wa] <= tab_wd;
        if (tab_re) r_tab_rd <= r_tab_mem[tab_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fs_we) r_fs_mem[r_depth[IDX_W-1:0]] <= req_idx;
        r_fs_rd <= r_fs_mem[depth_m1[IDX_W-1:0]];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_fresh     <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_fresh <= n_fresh;
            if (i_cmd.init_wr || i_cmd.clr_wr) r_ptr <= r_ptr + IDX_W'(1);
            else if (i_cmd.exec && o_sts.clear_go) r_ptr <= '0;
            if (emit)             r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_req;
            r_n   <= tab_ra;
        end else if (i_cmd.pop) begin
            r_n <= r_fs_rd;
        end
        if (i_cmd.exec && o_sts.range_go) r_left <= r_req.range_count;
        else if (i_cmd.rng_wr)             r_left <= r_left - RCNT_W'(1);
        if (emit) r_rsp <= rsp;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

endmodule

@@ hw/rtl/generational_handle_allocator_core.sv @@
// Generational handle allocator, top level. Depends on gha_pkg, gha_ctrl, gha_dpath.
// Sequencing: the request is taken in IDLE with a registered slot-table read, and the
// result is registered in EXEC (a create off the free stack passes POP first).
// reserve_range then steps RRD and RWR for each slot; clear steps CRD and CWR for each
// slot below the high-water mark, then CDONE. One request at a time; output stalls can
// lengthen all of these. Reset: synchronous, active low; afterwards a clearing pass
// in INIT zeroes the slot table with i_in_ready low.
`include "generational_handle_allocator_core_macros.svh"

module generational_handle_allocator_core
    import gha_pkg::*;
#(
    parameter int MAX_ENTITIES = 1024,
    parameter int GEN_BITS     = 16,
    parameter int MAX_RANGE    = 16
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_rsp
);

    // Controller sequences each request: accept and table read, optional free-stack
    // pop, then the read-modify-write in EXEC. Range and clear requests walk the
    // table slot by slot, a read state then a write state for each. A result register parts
    // the output side, so a request is taken while the previous result still waits.
    t_cmd cmd;
    t_sts sts;

    gha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    // Datapath: slot table (alive + generation), LIFO free stack, fresh counter.
    gha_dpath #(
        .MAX_ENTITIES (MAX_ENTITIES),
        .GEN_BITS     (GEN_BITS),
        .MAX_RANGE    (MAX_RANGE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_req    (i_in_req),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    // Busy straight after taking a request.
    `GHA_ASSERT_NEXT(a_busy_after_accept, cmd.accept, !o_in_ready, "ready after accept")
    // Controller issues at most one datapath command per cycle.
    `GHA_ASSERT(a_one_cmd, $onehot0(cmd), "overlapping datapath commands")
    // A null handle carries zero index and generation.
    `GHA_ASSERT(a_null_zero, !o_out_valid || o_out_rsp.out_valid ||
        (o_out_rsp.out_index == '0 && o_out_rsp.out_generation == '0), "non-zero null handle")

endmodule

@@ test/generational_handle_allocator_core_tb.sv @@
// Self-checking testbench for generational_handle_allocator_core.
// Depends on gha_pkg and the allocator RTL. Keeps its own slot table, free stack and
// fresh pointer, and checks every response against them in order.
module generational_handle_allocator_core_tb
    import gha_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = 1024;
    localparam int RANGE_MAX = 16;
    localparam int CYCLE_CAP = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_req i_in_req;
    logic o_out_valid;
    logic i_out_ready;
    t_rsp o_out_rsp;

    generational_handle_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    always #6 i_clk = ~i_clk;

    // Shadow of the slot table and allocator pointers.
    bit          slot_alive [SLOTS];
    logic [15:0] slot_gen   [SLOTS];
    logic [9:0]  free_stk   [SLOTS];
    int unsigned free_depth;
    int unsigned next_fresh;

    t_rsp rsp_due [$];
    int   fail_count;
    int   cycle_count;
    bit   no_gaps;   // stretch with back-to-back requests
    int   out_hold;
    bit   out_taken;

    function automatic t_rsp make_rsp(logic ok, t_status st, logic hv, logic [9:0] idx,
                                      logic [15:0] gen, logic lst);
        t_rsp r;
        r.ok             = ok;
        r.status         = st;
        r.out_valid      = hv;
        r.out_index      = hv ? idx : '0;
        r.out_generation = hv ? gen : '0;
        r.last           = lst;
        return r;
    endfunction

    function automatic bit handle_live(t_req r);
        if (!r.handle_valid || r.slot_index >= SLOTS) return 1'b0;
        return slot_alive[r.slot_index] && slot_gen[r.slot_index] == r.slot_generation;
    endfunction

    // Applies one accepted request to the shadow state and queues its responses.
    task automatic allocate_and_predict(t_req r);
        int unsigned n;
        case (r.func)
            FUNC_CREATE, FUNC_RESERVE: begin
                if (r.func == FUNC_CREATE && free_depth > 0) begin
                    free_depth--;
                    n = 32'(free_stk[free_depth]);
                end else if (next_fresh >= SLOTS) begin
                    next_fresh = SLOTS;
                    rsp_due.push_back(make_rsp(1'b0, ST_BUDGET, 1'b0, '0, '0, 1'b1));
                    return;
                end else begin
                    n = next_fresh;
                    next_fresh++;
                end
                if (r.func == FUNC_CREATE) slot_alive[n] = 1'b1;
                rsp_due.push_back(make_rsp(1'b1, ST_FINE, 1'b1, 10'(n), slot_gen[n], 1'b1));
            end
            FUNC_COMMIT: begin
                if (!r.handle_valid || r.slot_index >= SLOTS) begin
                    rsp_due.push_back(make_rsp(1'b0, ST_STALE, 1'b0, '0, '0, 1'b1));
                end else begin
                    slot_alive[r.slot_index] = 1'b1;
                    rsp_due.push_back(make_rsp(1'b1, ST_FINE, 1'b0, '0, '0, 1'b1));
                end
            end
            FUNC_RANGE: begin
                if (r.range_count == 0) begin
                    rsp_due.push_back(make_rsp(1'b1, ST_FINE, 1'b0, '0, '0, 1'b1));
                end else if (r.range_count > RANGE_MAX
                             || next_fresh + r.range_count > SLOTS) begin
                    rsp_due.push_back(make_rsp(1'b0, ST_BUDGET, 1'b0, '0, '0, 1'b1));
                end else begin
                    for (int i = 0; i < r.range_count; i++) begin
                        n = next_fresh + i;
                        slot_alive[n] = 1'b1;
                        rsp_due.push_back(make_rsp(1'b1, ST_FINE, 1'b1, 10'(n), slot_gen[n],
                                                   i + 1 == r.range_count));
                    end
                    next_fresh += r.range_count;
                end
            end
            FUNC_DESTROY: begin
                if (!handle_live(r)) begin
                    rsp_due.push_back(make_rsp(1'b0, ST_STALE, 1'b0, '0, '0, 1'b1));
                end else begin
                    slot_alive[r.slot_index] = 1'b0;
                    slot_gen[r.slot_index]   = slot_gen[r.slot_index] + 16'd1;
                    // a full free stack still retires the slot, it just drops the index
                    if (free_depth < SLOTS) begin
                        free_stk[free_depth] = r.slot_index[9:0];
                        free_depth++;
                    end
                    rsp_due.push_back(make_rsp(1'b1, ST_FINE, 1'b0, '0, '0, 1'b1));
                end
            end
            FUNC_IS_ALIVE: begin
                if (handle_live(r))
                    rsp_due.push_back(make_rsp(1'b1, ST_FINE, 1'b0, '0, '0, 1'b1));
                else
                    rsp_due.push_back(make_rsp(1'b0, ST_STALE, 1'b0, '0, '0, 1'b1));
            end
            FUNC_GET: begin
                if (r.slot_index >= SLOTS || !slot_alive[r.slot_index])
                    rsp_due.push_back(make_rsp(1'b0, ST_STALE, 1'b0, '0, '0, 1'b1));
                else
                    rsp_due.push_back(make_rsp(1'b1, ST_FINE, 1'b1, r.slot_index[9:0],
                                               slot_gen[r.slot_index], 1'b1));
            end
            default: begin
                // clear: retire everything below the high-water mark
                for (int i = 0; i < next_fresh && i < SLOTS; i++) begin
                    if (slot_alive[i]) slot_gen[i] = slot_gen[i] + 16'd1;
                    slot_alive[i] = 1'b0;
                end
                free_depth = 0;
                next_fresh = 0;
                rsp_due.push_back(make_rsp(1'b1, ST_FINE, 1'b0, '0, '0, 1'b1));
            end
        endcase
    endtask

    // Sends one request. Valid is left high on return, so a request with no gap
    // follows straight on without valid dropping.
    task automatic send_req(t_req r);
        int gap;
        if ($urandom_range(0, 31) == 0) no_gaps = ~no_gaps;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        // ready is sampled mid-cycle, well clear of the edge
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        allocate_and_predict(r);
    endtask

    task automatic send_op(t_func f, logic hv = 1'b1, logic [15:0] idx = '0,
                           logic [15:0] gen = '0, logic [4:0] cnt = '0);
        t_req r;
        r.func            = f;
        r.handle_valid    = hv;
        r.slot_index      = idx;
        r.slot_generation = gen;
        r.range_count     = cnt;
        send_req(r);
    endtask

    // Uses a slot's current generation, so the handle matches.
    function automatic logic [15:0] gen_of(int idx);
        return (idx < SLOTS) ? slot_gen[idx] : 16'h0;
    endfunction

    task automatic test_basic_ops();
        send_op(FUNC_CREATE);                               // fresh slot 0
        send_op(FUNC_RESERVE);                              // slot 1, not alive
        send_op(FUNC_GET, 1'b1, 16'd1);                     // reserved slot reads dead
        send_op(FUNC_COMMIT, 1'b1, 16'd1, 16'hFFFF);        // commit ignores generation
        send_op(FUNC_COMMIT, 1'b0, 16'd2);                  // null handle
        send_op(FUNC_COMMIT, 1'b1, 16'd1024);               // out of range
        send_op(FUNC_IS_ALIVE, 1'b1, 16'd0, gen_of(0));
        send_op(FUNC_IS_ALIVE, 1'b1, 16'd0, 16'hFFFF);      // generation mismatch
        send_op(FUNC_IS_ALIVE, 1'b0, 16'd0, gen_of(0));     // null handle
        send_op(FUNC_DESTROY, 1'b1, 16'd0, gen_of(0));
        send_op(FUNC_DESTROY, 1'b1, 16'd0, gen_of(0));      // already dead
        send_op(FUNC_CREATE);                               // pops slot 0 off the stack
        send_op(FUNC_GET, 1'b1, 16'd0);
        send_op(FUNC_GET, 1'b1, 16'hFFFF);                  // far out of range
        send_op(FUNC_RANGE, 1'b1, '0, '0, 5'd0);            // empty range
        send_op(FUNC_RANGE, 1'b1, '0, '0, 5'd17);           // longer than allowed
        send_op(FUNC_RANGE, 1'b1, '0, '0, 5'd31);
        send_op(FUNC_RANGE, 1'b1, '0, '0, 5'd16);
        send_op(FUNC_RANGE, 1'b1, '0, '0, 5'd3);
        send_op(FUNC_DESTROY, 1'b1, 16'd1025, 16'd0);       // out of range handle
        send_op(FUNC_CLEAR);
        send_op(FUNC_IS_ALIVE, 1'b1, 16'd0, 16'd1);         // stale after clear
        send_op(FUNC_IS_ALIVE, 1'b1, 16'd0, gen_of(0));
    endtask

    // Walks the fresh pointer to the top, then checks the budget limits.
    task automatic test_budget();
        repeat (63) send_op(FUNC_RANGE, 1'b1, '0, '0, 5'd16);
        send_op(FUNC_RANGE, 1'b1, '0, '0, 5'd12);           // up to 1020
        send_op(FUNC_RANGE, 1'b1, '0, '0, 5'd5);            // does not fit
        send_op(FUNC_RANGE, 1'b1, '0, '0, 5'd4);            // exactly fits
        send_op(FUNC_CREATE);                               // budget exhausted
        send_op(FUNC_RESERVE);
        send_op(FUNC_RANGE, 1'b1, '0, '0, 5'd1);
        send_op(FUNC_COMMIT, 1'b1, 16'd7);
        send_op(FUNC_DESTROY, 1'b1, 16'd7, gen_of(7));
        send_op(FUNC_CREATE);                               // reuses slot 7
        send_op(FUNC_GET, 1'b1, 16'd1023);
        send_op(FUNC_CLEAR);
    endtask

    task automatic test_random_traffic();
        t_req r;
        int   pick;
        int   hi;
        for (int k = 0; k < 224; k++) begin
            pick = $urandom_range(0, 99);
            hi   = (next_fresh + 1 < SLOTS) ? next_fresh + 1 : SLOTS - 1;
            r.func            = t_func'($urandom_range(0, 6));
            r.handle_valid    = ($urandom_range(0, 9) != 0);
            r.slot_index      = 16'($urandom_range(0, hi));
            r.slot_generation = gen_of(r.slot_index);
            r.range_count     = 5'($urandom_range(1, 6));
            if (pick < 10) begin
                // noise: anything the fields allow
                r.slot_index      = 16'($urandom());
                r.slot_generation = 16'($urandom());
                r.range_count     = 5'($urandom());
                r.handle_valid    = 1'($urandom());
            end else if (pick < 20) begin
                r.slot_generation = 16'($urandom());        // mostly stale handles
            end else if (pick < 24) begin
                r.range_count = 5'($urandom_range(0, 31));
            end
            if ($urandom_range(0, 59) == 0) r.func = FUNC_CLEAR;
            send_req(r);
        end
    endtask

    // Response side: random back-pressure, checked mid-cycle.
    always @(posedge i_clk) begin
        int h;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_hold    <= 0;
        end else begin
            h = out_hold;
            if (out_taken) h = no_gaps ? 0 : $urandom_range(0, 12);
            if (h > 0) begin
                i_out_ready <= 1'b0;
                out_hold    <= h - 1;
            end else begin
                i_out_ready <= 1'b1;
                out_hold    <= 0;
            end
        end
    end

    always @(negedge i_clk) begin
        t_rsp want;
        out_taken = 1'b0;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            out_taken = 1'b1;
            if (rsp_due.size() == 0) begin
                $error("response with none outstanding: %p", o_out_rsp);
                fail_count++;
            end else begin
                want = rsp_due.pop_front();
                if (o_out_rsp.ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, o_out_rsp.ok);
                    fail_count++;
                end
                if (o_out_rsp.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_rsp.status);
                    fail_count++;
                end
                if (o_out_rsp.out_valid !== want.out_valid) begin
                    $error("out_valid: expected %0d, got %0d",
                           want.out_valid, o_out_rsp.out_valid);
                    fail_count++;
                end
                if (o_out_rsp.out_index !== want.out_index) begin
                    $error("out_index: expected %0d, got %0d",
                           want.out_index, o_out_rsp.out_index);
                    fail_count++;
                end
                if (o_out_rsp.out_generation !== want.out_generation) begin
                    $error("out_generation: expected %0d, got %0d",
                           want.out_generation, o_out_rsp.out_generation);
                    fail_count++;
                end
                if (o_out_rsp.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_out_rsp.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog; the budget covers the post-reset clearing pass and worst-case stalls.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("generational_handle_allocator_core verification failed");
            $finish;
        end
    end

    initial begin
        no_gaps     = 1'b0;
        free_depth  = 0;
        next_fresh  = 0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_alive[i] = 1'b0;
            slot_gen[i]   = '0;
            free_stk[i]   = '0;
        end
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_req    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_budget();
        test_random_traffic();

        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (rsp_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("generational_handle_allocator_core verification clean");
        else
            $display("generational_handle_allocator_core verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/gha_pkg.sv
hw/rtl/gha_ctrl.sv
hw/rtl/gha_dpath.sv
hw/rtl/generational_handle_allocator_core.sv
test/generational_handle_allocator_core_tb.sv
